// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define OBK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obk assertion failed");

// next-cycle implication, held off during reset
`define OBK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obk assertion failed");

`endif

// ===== design/obk_pkg.sv =====
// ----------------------------------------------------------------------------
// obk_pkg
// types, constants and helpers of the price level order book
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obk_pkg;

  localparam int LEVELS  = 32;
  localparam int ADDR_W  = $clog2(LEVELS);
  localparam int CNT_W   = $clog2(LEVELS + 1);
  localparam int NT_W    = (CNT_W > 6) ? CNT_W : 6;
  localparam int MAX_OUT = 32;
  localparam int VAL_W   = 31;

  typedef enum logic [1:0] {
    FUNC_UPDATE,
    FUNC_LOOKUP,
    FUNC_TOP,
    FUNC_NOP
  } func_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_PRICE,
    ST_BAD_QTY,
    ST_FULL,
    ST_NONE
  } status_e;

  typedef enum logic [1:0] {
    MKT_ONE_SIDED,
    MKT_VALID,
    MKT_LOCKED,
    MKT_CROSSED
  } market_e;

  typedef struct packed {
    logic [VAL_W-1:0] price;
    logic [VAL_W-1:0] qty;
  } level_t;

  typedef struct packed {
    logic [VAL_W-1:0] bid_price;
    logic [VAL_W-1:0] bid_qty;
    logic [VAL_W-1:0] ask_price;
    logic [VAL_W-1:0] ask_qty;
    logic [1:0]       market_state;
    logic [31:0]      spread;
    logic [5:0]       bid_levels;
    logic [5:0]       ask_levels;
    logic [VAL_W-1:0] level_price;
    logic [VAL_W-1:0] level_qty;
    logic             last;
    logic [2:0]       status;
  } res_t;

  // true when price a sits ahead of price b on the side
  function automatic logic ranks_before(logic side, logic [VAL_W-1:0] a,
                                        logic [VAL_W-1:0] b);
    return side ? (a < b) : (a > b);
  endfunction

endpackage

// ===== design/obk_if.sv =====
// ----------------------------------------------------------------------------
// obk item channels
// valid/ready channels for request and result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface obk_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic               side;
  logic signed [31:0] price;
  logic signed [31:0] quantity;
  logic [5:0]         top_depth;

  modport source (output valid, func, side, price, quantity, top_depth, input ready);
  modport sink   (input valid, func, side, price, quantity, top_depth, output ready);
endinterface

interface obk_out_if;
  logic               valid;
  logic               ready;
  logic [30:0]        bid_price;
  logic [30:0]        bid_qty;
  logic [30:0]        ask_price;
  logic [30:0]        ask_qty;
  logic [1:0]         market_state;
  logic signed [31:0] spread;
  logic [5:0]         bid_levels;
  logic [5:0]         ask_levels;
  logic [30:0]        level_price;
  logic [30:0]        level_qty;
  logic               last;
  logic [2:0]         status;

  modport source (output valid, bid_price, bid_qty, ask_price, ask_qty, market_state,
                  spread, bid_levels, ask_levels, level_price, level_qty, last, status,
                  input ready);
  modport sink   (input valid, bid_price, bid_qty, ask_price, ask_qty, market_state,
                  spread, bid_levels, ask_levels, level_price, level_qty, last, status,
                  output ready);
endinterface

// ===== design/obk_ram.sv =====
// ----------------------------------------------------------------------------
// obk_ram
// one write, one read port memory with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obk_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 62
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/price_level_order_book_unit.sv =====
// ----------------------------------------------------------------------------
// price_level_order_book_unit
// sorted bid and ask level tables in one memory per side
// update: scans the entries, then shifts those behind an insert or a delete, one entry a cycle
// lookup: scans entries until a hit or the insertion point; top read: one result per level
// one item at a time; input ready only while idle; results wait in an output register
// reset clears level counts and the control state; table contents need no reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module price_level_order_book_unit (
  input  logic clk_i,
  input  logic rst_ni,
  obk_in_if.sink    in_i,
  obk_out_if.source out_o
);
  import obk_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHL, S_SHR, S_TOP, S_RESP} state_e;

  state_e           state_q, state_d;
  func_e            func_q, func_d;
  logic             side_q, side_d;
  logic [VAL_W-1:0] price_q, price_d, qty_q, qty_d;
  logic [CNT_W-1:0] idx_q, idx_d, ntop_q, ntop_d;
  logic [CNT_W-1:0] bid_cnt_q, ask_cnt_q;
  level_t           carry_q, carry_d, best_bid_q, best_ask_q;
  status_e          st_q, st_d;
  logic [VAL_W-1:0] lp_q, lp_d, lq_q, lq_d;
  logic             out_valid_q;
  res_t             out_q, res;

  logic             sel_side, we, re, cnt_inc, cnt_dec, out_load, out_last, out_free;
  logic [ADDR_W-1:0] waddr, raddr;
  level_t           wdata, rd, bid_rd, ask_rd, new_lvl;
  logic [CNT_W-1:0] n, cin;
  logic [CNT_W:0]   idx_p1, idx_p2;
  logic [VAL_W-1:0] out_lp, out_lq;
  status_e          out_st;
  logic             price_ok, qty_ok, match, ahead, at_end;
  logic [NT_W-1:0]  nt;

  obk_ram #(.DEPTH(LEVELS), .WIDTH($bits(level_t))) u_bid_ram (
    .clk_i, .we_i(we && !sel_side), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re && !sel_side), .raddr_i(raddr), .rdata_o(bid_rd)
  );

  obk_ram #(.DEPTH(LEVELS), .WIDTH($bits(level_t))) u_ask_ram (
    .clk_i, .we_i(we && sel_side), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re && sel_side), .raddr_i(raddr), .rdata_o(ask_rd)
  );

  assign sel_side = (state_q == S_IDLE) ? in_i.side : side_q;
  assign rd       = side_q ? ask_rd : bid_rd;
  assign n        = side_q ? ask_cnt_q : bid_cnt_q;
  assign cin      = in_i.side ? ask_cnt_q : bid_cnt_q;
  assign idx_p1   = {1'b0, idx_q} + (CNT_W+1)'(1);
  assign idx_p2   = {1'b0, idx_q} + (CNT_W+1)'(2);
  assign new_lvl  = '{price: price_q, qty: qty_q};
  assign match    = rd.price == price_q;
  assign ahead    = ranks_before(side_q, price_q, rd.price);
  assign at_end   = idx_p1 == {1'b0, n};
  assign price_ok = !in_i.price[31] && (in_i.price[30:0] != '0);
  assign qty_ok   = !in_i.quantity[31];
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = state_q == S_IDLE;

  always_comb begin
    nt = NT_W'(cin);
    if (NT_W'(in_i.top_depth) < nt) nt = NT_W'(in_i.top_depth);
    if (NT_W'(MAX_OUT) < nt) nt = NT_W'(MAX_OUT);
  end

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    side_d  = side_q;
    price_d = price_q;
    qty_d   = qty_q;
    idx_d   = idx_q;
    ntop_d  = ntop_q;
    carry_d = carry_q;
    st_d    = st_q;
    lp_d    = lp_q;
    lq_d    = lq_q;
    we      = 1'b0;
    waddr   = ADDR_W'(idx_q);
    wdata   = new_lvl;
    re      = 1'b0;
    raddr   = ADDR_W'(idx_p1);
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    out_load = 1'b0;
    out_last = 1'b1;
    out_lp  = lp_q;
    out_lq  = lq_q;
    out_st  = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          func_d  = func_e'(in_i.func);
          side_d  = in_i.side;
          price_d = in_i.price[VAL_W-1:0];
          qty_d   = in_i.quantity[VAL_W-1:0];
          idx_d   = '0;
          lp_d    = '0;
          lq_d    = '0;
          st_d    = ST_OK;
          state_d = S_RESP;
          raddr   = '0;
          unique case (func_e'(in_i.func))
            FUNC_UPDATE: begin
              if (!price_ok) begin
                st_d = ST_BAD_PRICE;
              end else if (!qty_ok) begin
                st_d = ST_BAD_QTY;
              end else if (cin == '0) begin
                if (in_i.quantity[VAL_W-1:0] != '0) begin
                  we      = 1'b1;
                  waddr   = '0;
                  wdata   = '{price: in_i.price[VAL_W-1:0], qty: in_i.quantity[VAL_W-1:0]};
                  cnt_inc = 1'b1;
                end
              end else begin
                re      = 1'b1;
                state_d = S_SCAN;
              end
            end
            FUNC_LOOKUP: begin
              if (!price_ok) begin
                st_d = ST_BAD_PRICE;
              end else if (cin == '0) begin
                st_d = ST_NONE;
              end else begin
                re      = 1'b1;
                state_d = S_SCAN;
              end
            end
            FUNC_TOP: begin
              if (nt == '0) begin
                st_d = ST_NONE;
              end else begin
                re      = 1'b1;
                ntop_d  = CNT_W'(nt);
                state_d = S_TOP;
              end
            end
            FUNC_NOP: begin
              st_d = ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (match) begin
          state_d = S_RESP;
          if (func_q == FUNC_LOOKUP) begin
            lp_d = price_q;
            lq_d = rd.qty;
          end else if (qty_q != '0) begin
            we = 1'b1;
          end else if (at_end) begin
            cnt_dec = 1'b1;
          end else begin
            re      = 1'b1;
            state_d = S_SHL;
          end
        end else if (ahead || at_end) begin
          state_d = S_RESP;
          if (func_q == FUNC_LOOKUP) begin
            st_d = ST_NONE;
          end else if (qty_q == '0) begin
            st_d = ST_OK;
          end else if (n == CNT_W'(LEVELS)) begin
            st_d = ST_FULL;
          end else if (ahead) begin
            we      = 1'b1;
            carry_d = rd;
            re      = 1'b1;
            idx_d   = CNT_W'(idx_p1);
            state_d = S_SHR;
          end else begin
            we      = 1'b1;
            waddr   = ADDR_W'(idx_p1);
            cnt_inc = 1'b1;
          end
        end else begin
          re    = 1'b1;
          idx_d = CNT_W'(idx_p1);
        end
      end
      S_SHL: begin
        we    = 1'b1;
        wdata = rd;
        if (idx_p2 == {1'b0, n}) begin
          cnt_dec = 1'b1;
          state_d = S_RESP;
        end else begin
          re    = 1'b1;
          raddr = ADDR_W'(idx_p2);
          idx_d = CNT_W'(idx_p1);
        end
      end
      S_SHR: begin
        we    = 1'b1;
        wdata = carry_q;
        if (idx_q == n) begin
          cnt_inc = 1'b1;
          state_d = S_RESP;
        end else begin
          carry_d = rd;
          re      = 1'b1;
          idx_d   = CNT_W'(idx_p1);
        end
      end
      S_TOP: begin
        out_lp   = rd.price;
        out_lq   = rd.qty;
        out_st   = ST_OK;
        out_last = idx_p1 == {1'b0, ntop_q};
        if (out_free) begin
          out_load = 1'b1;
          if (out_last) begin
            state_d = S_IDLE;
          end else begin
            re    = 1'b1;
            idx_d = CNT_W'(idx_p1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res              = '0;
    res.bid_levels   = 6'(bid_cnt_q);
    res.ask_levels   = 6'(ask_cnt_q);
    res.level_price  = out_lp;
    res.level_qty    = out_lq;
    res.last         = out_last;
    res.status       = out_st;
    res.market_state = MKT_ONE_SIDED;
    if (bid_cnt_q != '0) begin
      res.bid_price = best_bid_q.price;
      res.bid_qty   = best_bid_q.qty;
    end
    if (ask_cnt_q != '0) begin
      res.ask_price = best_ask_q.price;
      res.ask_qty   = best_ask_q.qty;
    end
    if (bid_cnt_q != '0 && ask_cnt_q != '0) begin
      res.spread = {1'b0, best_ask_q.price} - {1'b0, best_bid_q.price};
      priority if (best_bid_q.price < best_ask_q.price) res.market_state = MKT_VALID;
      else if (best_bid_q.price == best_ask_q.price) res.market_state = MKT_LOCKED;
      else res.market_state = MKT_CROSSED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bid_cnt_q   <= '0;
      ask_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cnt_inc || cnt_dec) begin
        if (sel_side) ask_cnt_q <= cnt_inc ? ask_cnt_q + 1'b1 : ask_cnt_q - 1'b1;
        else          bid_cnt_q <= cnt_inc ? bid_cnt_q + 1'b1 : bid_cnt_q - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    side_q  <= side_d;
    price_q <= price_d;
    qty_q   <= qty_d;
    idx_q   <= idx_d;
    ntop_q  <= ntop_d;
    carry_q <= carry_d;
    st_q    <= st_d;
    lp_q    <= lp_d;
    lq_q    <= lq_d;
    if (we && waddr == '0) begin
      if (sel_side) best_ask_q <= wdata;
      else          best_bid_q <= wdata;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.bid_price    = out_q.bid_price;
  assign out_o.bid_qty      = out_q.bid_qty;
  assign out_o.ask_price    = out_q.ask_price;
  assign out_o.ask_qty      = out_q.ask_qty;
  assign out_o.market_state = out_q.market_state;
  assign out_o.spread       = out_q.spread;
  assign out_o.bid_levels   = out_q.bid_levels;
  assign out_o.ask_levels   = out_q.ask_levels;
  assign out_o.level_price  = out_q.level_price;
  assign out_o.level_qty    = out_q.level_qty;
  assign out_o.last         = out_q.last;
  assign out_o.status       = out_q.status;

endmodule

// ===== design/obk_checker.sv =====
// ----------------------------------------------------------------------------
// obk_checker
// port level checks of the order book result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module obk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [30:0] bid_price_i,
  input logic [30:0] ask_price_i,
  input logic [1:0]  market_state_i,
  input logic [31:0] spread_i,
  input logic [5:0]  bid_levels_i,
  input logic [5:0]  ask_levels_i,
  input logic [2:0]  status_i
);
  import obk_pkg::*;

  `OBK_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `OBK_ASSERT_IMP(a_one_sided, clk_i, rst_ni,
                  out_valid_i && (bid_levels_i == '0 || ask_levels_i == '0),
                  market_state_i == MKT_ONE_SIDED && spread_i == '0)
  `OBK_ASSERT_IMP(a_empty_bid, clk_i, rst_ni, out_valid_i && bid_levels_i == '0,
                  bid_price_i == '0)
  `OBK_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_i,
                  status_i == ST_OK || status_i == ST_BAD_PRICE || status_i == ST_BAD_QTY ||
                  status_i == ST_FULL || status_i == ST_NONE)

endmodule

bind price_level_order_book_unit obk_checker u_obk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .bid_price_i    (out_o.bid_price),
  .ask_price_i    (out_o.ask_price),
  .market_state_i (out_o.market_state),
  .spread_i       (out_o.spread),
  .bid_levels_i   (out_o.bid_levels),
  .ask_levels_i   (out_o.ask_levels),
  .status_i       (out_o.status)
);
